FILE: rtl/sgd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sgd_pkg: shared types and constants for the sobel gradient block
// tangent thresholds in q2.32, direction codes, one square-root digit step
// ----------------------------------------------------------------------------
package sgd_pkg;

  localparam int PIX_W  = 8;
  localparam int GRAD_W = 10;                // |gx|, |gy| up to 1020
  localparam int SQ_W   = 2 * GRAD_W;        // one square
  localparam int SUM_W  = SQ_W + 1;          // sum of two squares
  localparam int RAD_W  = 16;                // radicand below 65536
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int THR_W  = 34;                // q2.32 tangent, integer part < 4
  localparam int PROD_W = THR_W + GRAD_W;

  // tan of the bin edges, angle in degrees with pi taken as 22/7
  localparam logic [THR_W-1:0] TAN_Q32_1DEG  = 34'd74999114;
  localparam logic [THR_W-1:0] TAN_Q32_11DEG = 34'd835201507;
  localparam logic [THR_W-1:0] TAN_Q32_61DEG = 34'd7756162675;
  localparam logic [THR_W-1:0] TAN_Q32_70DEG = 34'd11818405078;

  typedef enum logic [1:0] {
    DIR_0   = 2'd0,
    DIR_45  = 2'd1,
    DIR_90  = 2'd2,
    DIR_135 = 2'd3
  } dir_bin_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;    // radicand bits not yet consumed, msb first
    logic              clip;
    dir_bin_t          bin;
  } sqrt_t;

  // one restoring square-root digit
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    sqrt_t             r;
    logic [REM_W+1:0]  rem_t;
    logic [REM_W+1:0]  trial;
    begin
      r     = s;
      rem_t = {s.rem, s.rad[RAD_W-1 -: 2]};
      trial = {2'b00, s.root, 2'b01};
      r.rad = {s.rad[RAD_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        r.rem  = REM_W'(rem_t - trial);
        r.root = {s.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = REM_W'(rem_t);
        r.root = {s.root[ROOT_W-2:0], 1'b0};
      end
      return r;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/sobel_gradient_direction_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_gradient_direction_top: sobel 3x3 magnitude and quantized direction
// gradients, squares and tangent tests, then a four-stage square root
//
//   channel | dir | fields (lsb first)
//   in_     | in  | top_left top_mid top_right mid_left mid_right
//           |     | bottom_left bottom_mid bottom_right (8 bits each)
//   out_    | out | magnitude[7:0] magnitude_clipped[8] direction_bin[10:9]
//
// one window per cycle unless back-pressure at the output fills the pipeline
// most stages are the square root, two root bits per stage over four stages
// each stage moves when it is empty or the stage after it moves, so bubbles
// close up and an input beat is taken while a result waits at the output
// synchronous active-low reset clears the valid bits only
// ----------------------------------------------------------------------------
module sobel_gradient_direction_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // top_left, top_mid, top_right, mid_left,
                                       // mid_right, bottom_left, bottom_mid,
                                       // bottom_right
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // magnitude, magnitude_clipped,
                                       // direction_bin, zero fill
);
  import sgd_pkg::*;

  localparam int NSTG = 7;
  localparam int NSQ  = 4;

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] en;
  logic [NSTG-1:0] vld_in;

  // pipeline control
  always_comb begin
    en[NSTG-1] = !vld_r[NSTG-1] || out_tready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_in[0] = in_tvalid;
    for (int k = 1; k < NSTG; k++) begin
      vld_in[k] = vld_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_tready = en[0];

  // stage 0: sobel sums and absolute gradients
  logic [PIX_W-1:0]  tl, tm, tr, ml, mr, bl, bm, br;
  logic [GRAD_W-1:0] xp, xn, yp, yn;
  logic [GRAD_W:0]   dx, dy;
  logic [GRAD_W-1:0] ax_nxt, ay_nxt;
  logic [GRAD_W-1:0] ax_r, ay_r;
  logic              negx_r, negy_r;

  assign tl = in_tdata[7:0];
  assign tm = in_tdata[15:8];
  assign tr = in_tdata[23:16];
  assign ml = in_tdata[31:24];
  assign mr = in_tdata[39:32];
  assign bl = in_tdata[47:40];
  assign bm = in_tdata[55:48];
  assign br = in_tdata[63:56];

  always_comb begin
    xp = GRAD_W'(tr) + {1'b0, mr, 1'b0} + GRAD_W'(br);
    xn = GRAD_W'(tl) + {1'b0, ml, 1'b0} + GRAD_W'(bl);
    yp = GRAD_W'(tl) + {1'b0, tm, 1'b0} + GRAD_W'(tr);
    yn = GRAD_W'(bl) + {1'b0, bm, 1'b0} + GRAD_W'(br);
    dx = {1'b0, xp} - {1'b0, xn};
    dy = {1'b0, yp} - {1'b0, yn};
    ax_nxt = dx[GRAD_W] ? GRAD_W'(-dx) : dx[GRAD_W-1:0];
    ay_nxt = dy[GRAD_W] ? GRAD_W'(-dy) : dy[GRAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax_r   <= ax_nxt;
      ay_r   <= ay_nxt;
      negx_r <= dx[GRAD_W];
      negy_r <= dy[GRAD_W];
    end
  end

  // stage 1: squares and tangent products
  logic              same;
  logic [THR_W-1:0]  thr_lo, thr_hi;
  logic [SQ_W-1:0]   sqx_r, sqy_r;
  logic [PROD_W-1:0] plo_r, phi_r;
  logic [GRAD_W-1:0] ay1_r;
  logic              axz_r, ayz_r, same_r;

  always_comb begin
    same   = (negx_r == negy_r);
    thr_lo = same ? TAN_Q32_11DEG : TAN_Q32_1DEG;
    thr_hi = same ? TAN_Q32_61DEG : TAN_Q32_70DEG;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sqx_r  <= ax_r * ax_r;
      sqy_r  <= ay_r * ay_r;
      plo_r  <= PROD_W'(thr_lo) * PROD_W'(ax_r);
      phi_r  <= PROD_W'(thr_hi) * PROD_W'(ax_r);
      ay1_r  <= ay_r;
      axz_r  <= (ax_r == '0);
      ayz_r  <= (ay_r == '0);
      same_r <= same;
    end
  end

  // stage 2: sum of squares, overflow, direction bin
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] ay_sh;
  logic              lt_lo, lt_hi;
  dir_bin_t          bin_nxt;
  logic [RAD_W-1:0]  rad_r;
  logic              clip_r;
  dir_bin_t          bin_r;

  always_comb begin
    sum   = SUM_W'(sqx_r) + SUM_W'(sqy_r);
    ay_sh = {2'b00, ay1_r, 32'd0};
    lt_lo = ay_sh < plo_r;
    lt_hi = ay_sh < phi_r;
    priority if (axz_r) begin
      bin_nxt = ayz_r ? DIR_0 : DIR_90;
    end else if (ayz_r || lt_lo) begin
      bin_nxt = DIR_0;
    end else if (lt_hi) begin
      bin_nxt = same_r ? DIR_45 : DIR_135;
    end else begin
      bin_nxt = DIR_90;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      rad_r  <= sum[RAD_W-1:0];
      clip_r <= (sum[SUM_W-1:RAD_W] != '0);
      bin_r  <= bin_nxt;
    end
  end

  // stages 3 to 6: square root, two digits per stage
  sqrt_t sq_r  [NSQ];
  sqrt_t sq_in [NSQ];

  always_comb begin
    sq_in[0].rem  = '0;
    sq_in[0].root = '0;
    sq_in[0].rad  = rad_r;
    sq_in[0].clip = clip_r;
    sq_in[0].bin  = bin_r;
    for (int k = 1; k < NSQ; k++) begin
      sq_in[k] = sq_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSQ; k++) begin
      if (en[3+k]) begin
        sq_r[k] <= sqrt_step(sqrt_step(sq_in[k]));
      end
    end
  end

  // output
  logic [ROOT_W-1:0] mag;

  assign mag        = sq_r[NSQ-1].clip ? '1 : sq_r[NSQ-1].root;
  assign out_tvalid = vld_r[NSTG-1];
  assign out_tdata  = {5'd0, sq_r[NSQ-1].bin, sq_r[NSQ-1].clip, mag};

endmodule
`default_nettype wire

FILE: bench/tb_sobel_gradient_direction_top.sv
// ----------------------------------------------------------------------------
// tb_sobel_gradient_direction_top: self-checking bench for the sobel block
// windows go in as beats with random gaps, results come out under random
// back-pressure, and each result is checked against a sobel predictor that
// computes gx, gy, a floor square root with saturation and the direction bin
// ----------------------------------------------------------------------------
module tb_sobel_gradient_direction_top;

  import sgd_pkg::*;

  localparam int RANDOM_WINDOWS = 1100;
  localparam int DRAIN_CYCLES   = 20;     // pipeline is seven deep
  localparam int RUN_LIMIT      = 2_000_000;

  // top_left sits in bits 7:0, bottom_right in bits 63:56
  typedef struct packed {
    logic [7:0] bottom_right;
    logic [7:0] bottom_mid;
    logic [7:0] bottom_left;
    logic [7:0] mid_right;
    logic [7:0] mid_left;
    logic [7:0] top_right;
    logic [7:0] top_mid;
    logic [7:0] top_left;
  } sobel_window_t;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       clipped;
    dir_bin_t   bin;
  } grad_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;   // top_left .. bottom_right, 8 bits each
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;         // magnitude, magnitude_clipped, direction_bin

  sobel_window_t window_queue[$];
  grad_result_t  pending_grads[$];

  int  windows_total    = 0;
  int  windows_loaded   = 0;
  int  windows_accepted = 0;
  int  results_checked  = 0;
  int  mismatches       = 0;
  int  clipped_seen     = 0;
  int  bin_seen[4]      = '{0, 0, 0, 0};
  int  in_gap           = 0;
  int  out_stall        = 0;
  bit  in_took          = 1'b0;
  bit  out_took         = 1'b0;

  sobel_gradient_direction_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #4 clk = ~clk;

  // |gy| / |gx| below a q2.32 tangent, without forming the angle
  function automatic bit ratio_below(int ay, int ax, logic [THR_W-1:0] tan_q32);
    logic [63:0] lhs;
    logic [63:0] rhs;
    lhs = {32'(ay), 32'd0};
    rhs = 64'(tan_q32) * 64'(ax);
    return lhs < rhs;
  endfunction

  function automatic grad_result_t sobel_predict(sobel_window_t w);
    grad_result_t r;
    int gx, gy, ax, ay, sumsq, root;
    gx = (int'(w.top_right) + 2 * int'(w.mid_right) + int'(w.bottom_right))
       - (int'(w.top_left) + 2 * int'(w.mid_left) + int'(w.bottom_left));
    gy = (int'(w.top_left) + 2 * int'(w.top_mid) + int'(w.top_right))
       - (int'(w.bottom_left) + 2 * int'(w.bottom_mid) + int'(w.bottom_right));
    ax = (gx < 0) ? -gx : gx;
    ay = (gy < 0) ? -gy : gy;
    sumsq = ax * ax + ay * ay;

    if (sumsq >= 65536) begin
      r.magnitude = 8'd255;
      r.clipped   = 1'b1;
    end else begin
      root = 0;
      for (int b = 128; b > 0; b >>= 1) begin
        if ((root | b) * (root | b) <= sumsq) root = root | b;
      end
      r.magnitude = 8'(root);
      r.clipped   = 1'b0;
    end

    if (ax == 0) begin
      r.bin = (ay == 0) ? DIR_0 : DIR_90;
    end else if (ay == 0) begin
      r.bin = DIR_0;
    end else if ((gx < 0) == (gy < 0)) begin
      if (ratio_below(ay, ax, TAN_Q32_11DEG))      r.bin = DIR_0;
      else if (ratio_below(ay, ax, TAN_Q32_61DEG)) r.bin = DIR_45;
      else                                         r.bin = DIR_90;
    end else begin
      // negative angle folds up by 180
      if (ratio_below(ay, ax, TAN_Q32_1DEG))       r.bin = DIR_0;
      else if (ratio_below(ay, ax, TAN_Q32_70DEG)) r.bin = DIR_135;
      else                                         r.bin = DIR_90;
    end
    return r;
  endfunction

  function automatic sobel_window_t make_window(int tl, int tm, int tr, int ml,
                                                int mr, int bl, int bm, int br);
    sobel_window_t w;
    w.top_left     = 8'(tl);
    w.top_mid      = 8'(tm);
    w.top_right    = 8'(tr);
    w.mid_left     = 8'(ml);
    w.mid_right    = 8'(mr);
    w.bottom_left  = 8'(bl);
    w.bottom_mid   = 8'(bm);
    w.bottom_right = 8'(br);
    return w;
  endfunction

  function automatic logic [7:0] clamp_pixel(int v);
    return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
  endfunction

  // mix of noise, flat patches, ramps in every direction and hard edges
  function automatic sobel_window_t random_window();
    logic [63:0] bits;
    int mode, base, spread, slope_x, slope_y, col, row, idx;
    bits    = '0;
    mode    = $urandom_range(0, 7);
    base    = $urandom_range(0, 255);
    spread  = $urandom_range(1, 40);
    slope_x = $urandom_range(0, 40) - 20;
    slope_y = $urandom_range(0, 40) - 20;
    idx = 0;
    for (int p = 0; p < 9; p++) begin
      if (p != 4) begin
        col = (p % 3) - 1;
        row = (p / 3) - 1;
        case (mode)
          0, 1: begin
            bits[8*idx +: 8] = 8'($urandom);
          end
          2, 3: begin
            bits[8*idx +: 8] = clamp_pixel(base + $urandom_range(0, 2 * spread) - spread);
          end
          7: begin
            bits[8*idx +: 8] = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          end
          default: begin
            bits[8*idx +: 8] = clamp_pixel(base + slope_x * col + slope_y * row);
          end
        endcase
        idx++;
      end
    end
    return sobel_window_t'(bits);
  endfunction

  // quiet stretch of 64 beats out of every 256
  function automatic int draw_gap(int n);
    return (((n / 64) % 4) == 3) ? 0 : $urandom_range(0, 14);
  endfunction

  // input driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (window_queue.size() > 0) begin
        in_tdata       <= window_queue.pop_front();
        in_tvalid      <= 1'b1;
        in_gap         <= draw_gap(windows_loaded);
        windows_loaded <= windows_loaded + 1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure: a stall is drawn after every result beat
  always @(negedge clk) begin
    int s;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else if (out_took) begin
      s = draw_gap(results_checked);
      out_tready <= (s == 0);
      out_stall  <= (s == 0) ? 0 : s - 1;
    end else if (out_stall > 0) begin
      out_tready <= 1'b0;
      out_stall  <= out_stall - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    grad_result_t want;
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      results_checked <= results_checked + 1;
      if (pending_grads.size() == 0) begin
        $display("%0t: result beat with nothing expected: mag %0d clip %0d bin %0d",
                 $time, out_tdata[7:0], out_tdata[8], out_tdata[10:9]);
        mismatches <= mismatches + 1;
      end else begin
        want = pending_grads.pop_front();
        if (out_tdata[7:0] !== want.magnitude || out_tdata[8] !== want.clipped ||
            out_tdata[10:9] !== want.bin) begin
          $display("%0t: expected mag %0d clip %0d bin %0d, got mag %0d clip %0d bin %0d",
                   $time, want.magnitude, want.clipped, want.bin,
                   out_tdata[7:0], out_tdata[8], out_tdata[10:9]);
          mismatches <= mismatches + 1;
        end
        if (want.clipped) clipped_seen <= clipped_seen + 1;
        bin_seen[want.bin] <= bin_seen[want.bin] + 1;
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      pending_grads.push_back(sobel_predict(sobel_window_t'(in_tdata)));
      windows_accepted <= windows_accepted + 1;
    end
  end

  initial begin
    // flat windows in both extremes
    window_queue.push_back(make_window(0, 0, 0, 0, 0, 0, 0, 0));
    window_queue.push_back(make_window(255, 255, 255, 255, 255, 255, 255, 255));
    // full-scale horizontal and vertical edges, both signs
    window_queue.push_back(make_window(0, 0, 255, 0, 255, 0, 0, 255));
    window_queue.push_back(make_window(255, 0, 0, 255, 0, 255, 0, 0));
    window_queue.push_back(make_window(255, 255, 255, 0, 0, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 0, 255, 255, 255));
    // single corners: diagonals in all four quadrants
    window_queue.push_back(make_window(255, 0, 0, 0, 0, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 255, 0, 0, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 0, 0, 0, 255));
    window_queue.push_back(make_window(0, 0, 0, 0, 0, 255, 0, 0));
    // zero horizontal gradient with a vertical one, and the other way round
    window_queue.push_back(make_window(0, 1, 0, 0, 0, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 1, 0, 0, 0));
    // around the saturation point
    window_queue.push_back(make_window(0, 0, 0, 0, 127, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 1, 0, 127, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 128, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 0, 128, 0, 0, 0, 0));
    // either side of the 11, 70 and 1 degree edges, and either side of 60 degrees
    window_queue.push_back(make_window(0, 19, 0, 0, 100, 0, 0, 0));
    window_queue.push_back(make_window(0, 20, 0, 0, 100, 0, 0, 0));
    window_queue.push_back(make_window(0, 173, 0, 0, 100, 0, 0, 0));
    window_queue.push_back(make_window(0, 174, 0, 0, 100, 0, 0, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 50, 0, 137, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 50, 0, 138, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 255, 0, 4, 0));
    window_queue.push_back(make_window(0, 0, 0, 0, 255, 0, 5, 0));
    for (int i = 0; i < RANDOM_WINDOWS; i++) window_queue.push_back(random_window());
    windows_total = window_queue.size();

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    while (!(windows_accepted == windows_total && pending_grads.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d windows sent, %0d results checked, %0d saturated",
             windows_total, results_checked, clipped_seen);
    $display("direction bins 0/45/90/135 deg: %0d/%0d/%0d/%0d",
             bin_seen[0], bin_seen[1], bin_seen[2], bin_seen[3]);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT);
    $display("timeout with %0d results still expected", pending_grads.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
